// File: src/nsp_pkg.sv
// Shared types, constants and helper function of the numeric string parser.
package nsp_pkg;

  localparam int MAX_LEN_DEF = 255;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;
  localparam int BASE_W     = 6;
  localparam int CHAR_W     = 8;
  localparam int VALUE_W    = 64;
  localparam int DIGIT_W    = 5;
  localparam int STOP_W     = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SELECT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MODE = 1'd1;

  localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
  localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
  localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_A_UP  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_F_UP  = 8'h46;
  localparam logic [CHAR_W-1:0] CH_A_LO  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_F_LO  = 8'h66;
  localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;

  localparam logic [DIGIT_W-1:0] NOT_DIGIT = 5'd16;

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_SIGNED,
    PH_ZERO,
    PH_XSEEN,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  // Per-string parse state (position counters are kept apart, their width
  // follows the length limit).
  typedef struct packed {
    phase_t               phase;
    logic [BASE_W-1:0]    active_base;
    logic [VALUE_W-1:0]   acc;
    logic                 neg;
    logic                 seen;
    logic                 ovf;
  } parse_state_t;

  localparam parse_state_t STATE_CLEAR = '{
    phase:       PH_SPACE,
    active_base: '0,
    acc:         '0,
    neg:         1'b0,
    seen:        1'b0,
    ovf:         1'b0
  };

  // Hex digit value, NOT_DIGIT for anything else.
  function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [DIGIT_W-1:0] d;
    d = NOT_DIGIT;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = DIGIT_W'(c - CH_ZERO);
    end else if (c >= CH_A_LO && c <= CH_F_LO) begin
      d = DIGIT_W'(c - CH_A_LO + 8'd10);
    end else if (c >= CH_A_UP && c <= CH_F_UP) begin
      d = DIGIT_W'(c - CH_A_UP + 8'd10);
    end
    return d;
  endfunction

endpackage

// File: src/nsp_step.sv
// Next-state logic of the parser for one character: phase, base, multiply-add.
module nsp_step #(
  parameter int MAX_LEN = nsp_pkg::MAX_LEN_DEF,
  parameter int POS_W   = $clog2(MAX_LEN + 1)
) (
  input  nsp_pkg::parse_state_t             st,
  input  logic [POS_W-1:0]                  pos,
  input  logic [POS_W-1:0]                  stop,
  input  logic [nsp_pkg::CHAR_W-1:0]        ch,
  input  logic [nsp_pkg::BASE_W-1:0]        base_sel,
  output nsp_pkg::parse_state_t             st_next,
  output logic [POS_W-1:0]                  pos_next,
  output logic [POS_W-1:0]                  stop_next
);

  localparam int PROD_W = nsp_pkg::VALUE_W + nsp_pkg::BASE_W;

  logic [nsp_pkg::DIGIT_W-1:0] d;
  logic                        first_phase;
  logic                        first_zero;
  logic [nsp_pkg::BASE_W-1:0]  first_base;
  logic [nsp_pkg::BASE_W-1:0]  use_base;
  logic [PROD_W-1:0]           prod;
  logic                        digit_ok;
  logic                        is_space;
  logic                        is_x;
  logic [POS_W-1:0]            pos_inc;

  assign d           = nsp_pkg::digit_of(ch);
  assign first_phase = (st.phase == nsp_pkg::PH_SPACE) || (st.phase == nsp_pkg::PH_SIGNED);
  assign first_zero  = (ch == nsp_pkg::CH_ZERO) &&
                       (base_sel == nsp_pkg::BASE_AUTO || base_sel == nsp_pkg::BASE_HEX);
  assign first_base  = (base_sel == nsp_pkg::BASE_AUTO) ? nsp_pkg::BASE_DEC : base_sel;
  assign use_base    = first_phase ? first_base : st.active_base;
  // acc is zero in the leading phases, so one multiplier serves all cases.
  assign prod        = PROD_W'(st.acc) * PROD_W'(use_base) + PROD_W'(d);
  assign digit_ok    = (d != nsp_pkg::NOT_DIGIT) && ({1'b0, d} < use_base);
  assign is_space    = (ch == nsp_pkg::CH_SPACE) ||
                       (ch inside {[nsp_pkg::CH_TAB:nsp_pkg::CH_CR]});
  assign is_x        = (ch == nsp_pkg::CH_X_LO) || (ch == nsp_pkg::CH_X_UP);
  assign pos_inc     = pos + POS_W'(1);

  always_comb begin
    logic take;
    take      = 1'b0;
    st_next   = st;
    stop_next = stop;
    pos_next  = pos;

    if (pos >= POS_W'(MAX_LEN)) begin
      st_next.phase = nsp_pkg::PH_DONE;
    end else begin
      pos_next = pos_inc;
      case (st.phase)
        nsp_pkg::PH_SPACE: begin
          if (is_space) begin
            take = 1'b0;
          end else if (ch == nsp_pkg::CH_MINUS) begin
            st_next.neg   = 1'b1;
            st_next.phase = nsp_pkg::PH_SIGNED;
          end else if (ch == nsp_pkg::CH_PLUS) begin
            st_next.phase = nsp_pkg::PH_SIGNED;
          end else begin
            take = 1'b1;
          end
        end
        nsp_pkg::PH_SIGNED: begin
          take = 1'b1;
        end
        nsp_pkg::PH_ZERO: begin
          if (is_x) begin
            st_next.active_base = nsp_pkg::BASE_HEX;
            st_next.phase       = nsp_pkg::PH_XSEEN;
          end else begin
            take = 1'b1;
          end
        end
        nsp_pkg::PH_XSEEN, nsp_pkg::PH_DIGITS: begin
          take = 1'b1;
        end
        default: begin
          take = 1'b0;
        end
      endcase

      if (take) begin
        if (first_phase && first_zero) begin
          // leading zero: counts as a digit, may open an 0x prefix
          st_next.active_base = (base_sel == nsp_pkg::BASE_AUTO) ?
                                nsp_pkg::BASE_OCT : nsp_pkg::BASE_HEX;
          st_next.acc         = '0;
          st_next.seen        = 1'b1;
          st_next.phase       = nsp_pkg::PH_ZERO;
          stop_next           = pos_inc;
        end else begin
          st_next.active_base = use_base;
          if (digit_ok) begin
            st_next.acc   = prod[nsp_pkg::VALUE_W-1:0];
            st_next.ovf   = st.ovf | (|prod[PROD_W-1:nsp_pkg::VALUE_W]);
            st_next.seen  = 1'b1;
            st_next.phase = nsp_pkg::PH_DIGITS;
            stop_next     = pos_inc;
          end else begin
            st_next.phase = nsp_pkg::PH_DONE;
          end
        end
      end
    end
  end

endmodule

// File: src/numeric_string_parser.sv
// Top level of the streaming string-to-integer parser.
//
// The parser takes one character per item and turns a string into a 64-bit
// integer the way strtoull/strtoll do: leading white space is skipped, one
// '+' or '-' is taken, base_select 0 detects the radix (0x -> 16, 0 -> 8,
// else 10), base 16 also skips a 0x prefix, and digits below the base are
// accumulated modulo 2^64 with a sticky wrapped flag. The item with
// last_char set produces one result (value, minus_seen, stop_index,
// no_digits, wrapped) and clears the per-string state; all other items
// produce nothing. Throughput is one item per clock, with or without
// results, except while a last item waits for the output register. An item
// passes the input register and its result is held in the output register.
// The cycle is set by the multiply-add of the accumulator by a 6-bit base in
// the step logic. A last item waits in the input register only while the
// output register holds a result that has not been taken. Configuration
// (base_select at index 0, signed_mode at index 1) is always ready and must
// be written while no string is in flight. Strings longer than MAX_LEN
// characters stop parsing at that offset.
module numeric_string_parser #(
  parameter int MAX_LEN = nsp_pkg::MAX_LEN_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // character input
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [nsp_pkg::CHAR_W-1:0]         char_code,
  input  logic                               last_char,
  // result output
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [nsp_pkg::VALUE_W-1:0]        value_bits,
  output logic                               minus_seen,
  output logic [nsp_pkg::STOP_W-1:0]         stop_index,
  output logic                               no_digits,
  output logic                               wrapped,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [nsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nsp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int POS_W = $clog2(MAX_LEN + 1);

  // config registers
  logic [nsp_pkg::BASE_W-1:0] base_select;
  logic                       signed_mode;

  // input register
  logic                        s1_valid;
  logic [nsp_pkg::CHAR_W-1:0]  s1_char;
  logic                        s1_last;
  logic                        advance;

  // parse state
  nsp_pkg::parse_state_t st;
  nsp_pkg::parse_state_t st_next;
  logic [POS_W-1:0]      pos;
  logic [POS_W-1:0]      pos_next;
  logic [POS_W-1:0]      stop;
  logic [POS_W-1:0]      stop_next;
  logic [POS_W+nsp_pkg::STOP_W-1:0] stop_wide;

  // result register; negation is applied on the way out
  logic [nsp_pkg::VALUE_W-1:0] res_acc;
  logic                        res_negate;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_select <= nsp_pkg::BASE_RESET;
      signed_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        nsp_pkg::CFG_BASE_SELECT: base_select <= cfg_data;
        nsp_pkg::CFG_SIGNED_MODE: signed_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // A non-last item always moves on; a last item needs the output slot.
  assign advance  = s1_valid && (!s1_last || !out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_char <= char_code;
      s1_last <= last_char;
    end
  end

  nsp_step #(
    .MAX_LEN (MAX_LEN),
    .POS_W   (POS_W)
  ) u_step (
    .st        (st),
    .pos       (pos),
    .stop      (stop),
    .ch        (s1_char),
    .base_sel  (base_select),
    .st_next   (st_next),
    .pos_next  (pos_next),
    .stop_next (stop_next)
  );

  // State updates per item; the last item of a string clears it.
  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= nsp_pkg::STATE_CLEAR;
      pos  <= '0;
      stop <= '0;
    end else if (advance) begin
      if (s1_last) begin
        st   <= nsp_pkg::STATE_CLEAR;
        pos  <= '0;
        stop <= '0;
      end else begin
        st   <= st_next;
        pos  <= pos_next;
        stop <= stop_next;
      end
    end
  end

  assign stop_wide = {{nsp_pkg::STOP_W{1'b0}}, stop_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last) begin
      res_acc    <= st_next.acc;
      res_negate <= signed_mode && st_next.neg;
      minus_seen <= st_next.neg;
      // no digit: end pointer falls back to the string start
      stop_index <= st_next.seen ? stop_wide[nsp_pkg::STOP_W-1:0] : '0;
      no_digits  <= !st_next.seen;
      wrapped    <= st_next.ovf;
    end
  end

  assign value_bits = res_negate ? (nsp_pkg::VALUE_W'(0) - res_acc) : res_acc;

endmodule
